// ----- sv/sphc_pkg.sv -----
// shared types and constants for the sphere collision pair tracker
package sphc_pkg;

    localparam int RADIUS_W = 31;
    localparam int OPND_W   = 32;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int SLOT_W   = 3;

    // calc sequence: operands issued on steps 0..3, squares summed on 2..4, compare on 5
    localparam logic [2:0] STEP_LAST_OPND = 3'd3;
    localparam logic [2:0] STEP_ADD_FIRST = 3'd2;
    localparam logic [2:0] STEP_ADD_LAST  = 3'd4;
    localparam logic [2:0] STEP_CMP       = 3'd5;

    localparam logic [1:0] SEL_X    = 2'd0;
    localparam logic [1:0] SEL_Y    = 2'd1;
    localparam logic [1:0] SEL_Z    = 2'd2;
    localparam logic [1:0] SEL_RSUM = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_DROP  = 2'd1,
        OP_FRAME = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        EV_ENTER = 2'd0,
        EV_STAY  = 2'd1,
        EV_EXIT  = 2'd2
    } t_kind;

    typedef struct packed {
        logic       load;
        logic       drop;
        logic       rd_b;
        logic       cap_a;
        logic       cap_b;
        logic       acc_clr;
        logic       opnd_ld;
        logic [1:0] opnd_sel;
        logic       acc_add;
        logic       push;
        t_kind      kind;
        logic       set_act;
        logic       clr_act;
        logic       flush;
    } t_dp_cmd;

    typedef struct packed {
        logic pres_a;
        logic pres_b;
        logic act;
        logic touch;
        logic pend_v;
        logic can_push;
    } t_dp_status;

endpackage

// ----- sv/sphc_ram.sv -----
// generic single write port ram with registered read
module sphc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- sv/sphc_dp.sv -----
// datapath: entity store, presence and pair flags, squared distance unit, event output
module sphc_dp #(
    parameter int MAX_ENTITIES = 8,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sphc_pkg::t_dp_cmd               i_cmd,
    output sphc_pkg::t_dp_status            o_st,
    input  logic [$clog2(MAX_ENTITIES)-1:0] i_idx,
    input  logic [$clog2(MAX_ENTITIES)-1:0] i_pair_a,
    input  logic [$clog2(MAX_ENTITIES)-1:0] i_pair_b,
    input  logic [31:0]                     i_pos_x,
    input  logic [31:0]                     i_pos_y,
    input  logic [31:0]                     i_pos_z,
    input  logic [30:0]                     i_radius,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_event_kind,
    output logic [2:0]                      o_first_slot,
    output logic [2:0]                      o_second_slot,
    output logic                            o_last_event
);
    import sphc_pkg::*;

    localparam int IW = $clog2(MAX_ENTITIES);
    localparam int CW = COORD_WIDTH;
    localparam int EW = 3 * CW + RADIUS_W;

    // entity word: {radius, z, y, x}
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;
    logic [IW-1:0] rd_addr;

    logic [EW-1:0] r_ent_a;
    logic [EW-1:0] r_ent_b;

    logic [MAX_ENTITIES-1:0] r_present;
    logic [MAX_ENTITIES-1:0] r_active [MAX_ENTITIES];

    logic [OPND_W-1:0] r_opnd;
    logic [OPND_W-1:0] n_opnd;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;

    logic              r_pend_v;
    t_kind             r_pend_kind;
    logic [SLOT_W-1:0] r_pend_a;
    logic [SLOT_W-1:0] r_pend_b;

    logic              r_out_v;
    t_kind             r_out_kind;
    logic [SLOT_W-1:0] r_out_a;
    logic [SLOT_W-1:0] r_out_b;
    logic              r_out_last;

    logic out_free;

    logic signed [CW-1:0] ca;
    logic signed [CW-1:0] cb;
    logic signed [CW:0]   diff;
    logic [CW:0]          dmag;
    logic [OPND_W-1:0]    rsum;

    logic [IW+SLOT_W-1:0] a_ext;
    logic [IW+SLOT_W-1:0] b_ext;

    assign wr_data = {i_radius, i_pos_z[CW-1:0], i_pos_y[CW-1:0], i_pos_x[CW-1:0]};
    assign rd_addr = i_cmd.rd_b ? i_pair_b : i_pair_a;

    sphc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTITIES)
    ) u_ent_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.load),
        .i_wr_addr (i_idx),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // operand select: coordinate distance magnitude or radius sum
    always_comb begin
        ca = r_ent_a[CW-1:0];
        cb = r_ent_b[CW-1:0];
        case (i_cmd.opnd_sel)
            SEL_X: begin
                ca = r_ent_a[CW-1:0];
                cb = r_ent_b[CW-1:0];
            end
            SEL_Y: begin
                ca = r_ent_a[2*CW-1:CW];
                cb = r_ent_b[2*CW-1:CW];
            end
            SEL_Z: begin
                ca = r_ent_a[3*CW-1:2*CW];
                cb = r_ent_b[3*CW-1:2*CW];
            end
            default: begin
                ca = r_ent_a[CW-1:0];
                cb = r_ent_b[CW-1:0];
            end
        endcase
        diff = {ca[CW-1], ca} - {cb[CW-1], cb};
        dmag = diff[CW] ? (-diff) : diff;
        rsum = OPND_W'({1'b0, r_ent_a[EW-1:3*CW]}) + OPND_W'({1'b0, r_ent_b[EW-1:3*CW]});
        n_opnd = (i_cmd.opnd_sel == SEL_RSUM) ? rsum : OPND_W'(dmag[CW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_ent_a <= rd_data;
        end
        if (i_cmd.cap_b) begin
            r_ent_b <= rd_data;
        end
        if (i_cmd.opnd_ld) begin
            r_opnd <= n_opnd;
        end
        r_prod <= r_opnd * r_opnd;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // presence and pair activity flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            for (int i = 0; i < MAX_ENTITIES; i++) begin
                r_active[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_present[i_idx] <= 1'b1;
            end else if (i_cmd.drop) begin
                r_present[i_idx] <= 1'b0;
            end
            if (i_cmd.set_act) begin
                r_active[i_pair_a][i_pair_b] <= 1'b1;
            end else if (i_cmd.clr_act) begin
                r_active[i_pair_a][i_pair_b] <= 1'b0;
            end
        end
    end

    // one event is held back so the final one of a frame can be marked
    assign out_free = !r_out_v || !i_out_stall;
    assign a_ext    = {{SLOT_W{1'b0}}, i_pair_a};
    assign b_ext    = {{SLOT_W{1'b0}}, i_pair_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if ((i_cmd.push || i_cmd.flush) && r_pend_v) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_pend_kind <= i_cmd.kind;
            r_pend_a    <= a_ext[SLOT_W-1:0];
            r_pend_b    <= b_ext[SLOT_W-1:0];
        end
        if ((i_cmd.push || i_cmd.flush) && r_pend_v) begin
            r_out_kind <= r_pend_kind;
            r_out_a    <= r_pend_a;
            r_out_b    <= r_pend_b;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_event_kind  = r_out_kind;
    assign o_first_slot  = r_out_a;
    assign o_second_slot = r_out_b;
    assign o_last_event  = r_out_last;

    assign o_st.pres_a   = r_present[i_pair_a];
    assign o_st.pres_b   = r_present[i_pair_b];
    assign o_st.act      = r_active[i_pair_a][i_pair_b];
    assign o_st.touch    = (r_acc[ACC_W-1:PROD_W] == 2'b00) && (r_acc[PROD_W-1:0] <= r_prod);
    assign o_st.pend_v   = r_pend_v;
    assign o_st.can_push = !r_pend_v || out_free;
endmodule

// ----- sv/sphc_ctrl.sv -----
// controller: item decode, pair walk and calc sequencing
module sphc_ctrl #(
    parameter int MAX_ENTITIES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_opcode,
    input  logic [2:0]                      i_slot,
    input  sphc_pkg::t_dp_status            i_st,
    output sphc_pkg::t_dp_cmd               o_cmd,
    output logic [$clog2(MAX_ENTITIES)-1:0] o_idx,
    output logic [$clog2(MAX_ENTITIES)-1:0] o_pair_a,
    output logic [$clog2(MAX_ENTITIES)-1:0] o_pair_b
);
    import sphc_pkg::*;

    localparam int IW = $clog2(MAX_ENTITIES);
    localparam logic [IW-1:0] A_LAST = IW'(MAX_ENTITIES - 2);
    localparam logic [IW-1:0] B_LAST = IW'(MAX_ENTITIES - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAIR  = 7'b0000010,
        S_RDA   = 7'b0000100,
        S_RDB   = 7'b0001000,
        S_CAPB  = 7'b0010000,
        S_CALC  = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [IW-1:0] r_a;
    logic [IW-1:0] n_a;
    logic [IW-1:0] r_b;
    logic [IW-1:0] n_b;
    logic [2:0]    r_step;
    logic [2:0]    n_step;

    logic                accept;
    logic                slot_ok;
    logic [IW+SLOT_W-1:0] slot_ext;
    logic                advance;
    logic                do_emit;
    t_kind               emit_kind;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign slot_ok  = 32'(i_slot) < MAX_ENTITIES;
    assign slot_ext = {{IW{1'b0}}, i_slot};

    assign o_in_stall = (r_state != S_IDLE);
    assign o_idx      = slot_ext[IW-1:0];
    assign o_pair_a   = r_a;
    assign o_pair_b   = r_b;

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_step    = r_step;
        o_cmd     = '0;
        o_cmd.kind = EV_ENTER;
        advance   = 1'b0;
        do_emit   = 1'b0;
        emit_kind = EV_EXIT;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_opcode))
                        OP_LOAD: o_cmd.load = slot_ok;
                        OP_DROP: o_cmd.drop = slot_ok;
                        OP_FRAME: begin
                            n_a     = '0;
                            n_b     = IW'(1);
                            n_state = S_PAIR;
                        end
                        default: ;
                    endcase
                end
            end
            S_PAIR: begin
                if (i_st.pres_a && i_st.pres_b) begin
                    n_state = S_RDA;
                end else if (i_st.act) begin
                    do_emit   = 1'b1;
                    emit_kind = EV_EXIT;
                end else begin
                    advance = 1'b1;
                end
            end
            S_RDA: begin
                n_state = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_b  = 1'b1;
                o_cmd.cap_a = 1'b1;
                n_state     = S_CAPB;
            end
            S_CAPB: begin
                o_cmd.cap_b   = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_step        = '0;
                n_state       = S_CALC;
            end
            S_CALC: begin
                o_cmd.opnd_sel = r_step[1:0];
                o_cmd.opnd_ld  = (r_step <= STEP_LAST_OPND);
                o_cmd.acc_add  = (r_step >= STEP_ADD_FIRST) && (r_step <= STEP_ADD_LAST);
                if (r_step != STEP_CMP) begin
                    n_step = r_step + 3'd1;
                end else if (i_st.touch) begin
                    do_emit   = 1'b1;
                    emit_kind = i_st.act ? EV_STAY : EV_ENTER;
                end else if (i_st.act) begin
                    do_emit   = 1'b1;
                    emit_kind = EV_EXIT;
                end else begin
                    advance = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!i_st.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_st.can_push) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // hold in place until the held-back event can move on
        if (do_emit && i_st.can_push) begin
            o_cmd.push    = 1'b1;
            o_cmd.kind    = emit_kind;
            o_cmd.set_act = (emit_kind == EV_ENTER);
            o_cmd.clr_act = (emit_kind == EV_EXIT);
            advance       = 1'b1;
        end

        if (advance) begin
            if (r_b != B_LAST) begin
                n_b     = r_b + IW'(1);
                n_state = S_PAIR;
            end else if (r_a != A_LAST) begin
                n_a     = r_a + IW'(1);
                n_b     = r_a + IW'(2);
                n_state = S_PAIR;
            end else begin
                n_state = S_FLUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a     <= '0;
            r_b     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
            r_step  <= n_step;
        end
    end
endmodule

// ----- sv/sphere_collision_pair_tracker.sv -----
// top level of the sphere collision pair tracker
//
// keeps up to MAX_ENTITIES sphere entities (signed Q16.16 position, unsigned
// Q15.16 radius) and a touching flag per slot pair. a load beat writes an
// entity and marks it present, a drop beat clears its presence; both give no
// result. an end-of-frame beat walks every pair (a, b) with
// a < b in ascending order and emits enter, stay or exit beats, the final one
// of the frame flagged by o_last_event; a frame with no events gives nothing.
// the touch test is exact: dx^2 + dy^2 + dz^2 <= (ra + rb)^2 in Q32.32 with
// no rounding. a pair with an absent slot counts as not touching. loads or
// drops to a slot at or above MAX_ENTITIES and opcode three are ignored.
// a pair with an absent slot is settled in the S_PAIR state; a pair of present
// slots goes on through S_RDA, S_RDB, S_CAPB and the calc steps, reading both
// entities through the single read port of the entity ram and passing four
// operands (three distance terms and the radius sum) through one shared 32x32
// multiplier with registered product and accumulator. a closing S_FLUSH state
// releases the last event, and output stalls can hold the walk. input stall
// stays high for the whole walk; finished events wait in a pending register
// and an output register, so the walk keeps going while the consumer stalls
// until both are full and another event is due.
module sphere_collision_pair_tracker #(
    parameter int MAX_ENTITIES = 8,
    parameter int COORD_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_slot,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [30:0] i_radius,
    // event channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_kind,
    output logic [2:0]  o_first_slot,
    output logic [2:0]  o_second_slot,
    output logic        o_last_event
);
    import sphc_pkg::*;

    localparam int IW = $clog2(MAX_ENTITIES);

    t_dp_cmd    cmd;
    t_dp_status st;
    logic [IW-1:0] idx;
    logic [IW-1:0] pair_a;
    logic [IW-1:0] pair_b;

    // decode and pair walk
    sphc_ctrl #(
        .MAX_ENTITIES (MAX_ENTITIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_slot     (i_slot),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_idx      (idx),
        .o_pair_a   (pair_a),
        .o_pair_b   (pair_b)
    );

    // entity store, distance unit and event output register
    sphc_dp #(
        .MAX_ENTITIES (MAX_ENTITIES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_idx         (idx),
        .i_pair_a      (pair_a),
        .i_pair_b      (pair_b),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_radius      (i_radius),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_first_slot  (o_first_slot),
        .o_second_slot (o_second_slot),
        .o_last_event  (o_last_event)
    );
endmodule

// ----- verif/sphere_collision_pair_tracker_tb.sv -----
// self-checking testbench for the sphere collision pair tracker: directed table, then random beats
`timescale 1ns / 100ps

module sphere_collision_pair_tracker_tb;
    import sphc_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 10;
    localparam int          SLOT_COUNT   = 8;
    localparam int          RANDOM_BEATS = 88;    // per idle phase, ignored beats not counted
    localparam int          HOLD_CYCLES  = 400;   // long consumer hold-off
    localparam int          TAIL_CYCLES  = 400;   // longer than a full 28-pair walk
    localparam int          QUIET_LIMIT  = 5000;  // cycles without any accepted beat
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [31:0] Q_ZERO       = 32'h0000_0000;
    localparam logic [31:0] Q_TWO        = 32'h0002_0000;
    localparam logic [31:0] Q_TWO_PLUS   = 32'h0002_0001;
    localparam logic [31:0] COORD_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] CLUSTER_SPAN = 32'h0008_0000;  // +-4.0 around the origin
    localparam logic [30:0] R_ZERO       = 31'h0000_0000;
    localparam logic [30:0] R_ONE        = 31'h0001_0000;
    localparam logic [30:0] R_MAX        = 31'h7FFF_FFFF;
    localparam logic [30:0] R_CLUSTER    = 31'h0002_0000;

    // one item beat, with an optional typed-in frame outcome of zero or one event
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] r;
        logic        has_golden;
        logic        golden_event;
        t_kind       golden_kind;
        logic [2:0]  golden_a;
        logic [2:0]  golden_b;
    } stim_row_t;

    typedef struct {
        t_kind      kind;
        logic [2:0] first_slot;
        logic [2:0] second_slot;
        logic       last_event;
    } pair_event_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_opcode      = '0;
    logic [2:0]  i_slot        = '0;
    logic [31:0] i_pos_x       = '0;
    logic [31:0] i_pos_y       = '0;
    logic [31:0] i_pos_z       = '0;
    logic [30:0] i_radius      = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_event_kind;
    logic [2:0]  o_first_slot;
    logic [2:0]  o_second_slot;
    logic        o_last_event;

    // predictor state: world table and per-pair contact bits
    bit          slot_present  [SLOT_COUNT];
    logic [31:0] entity_xyz    [SLOT_COUNT][3];
    logic [30:0] entity_r      [SLOT_COUNT];
    bit          pair_touching [SLOT_COUNT][SLOT_COUNT];

    pair_event_t walk_events[$];     // events of the beat just accepted
    pair_event_t pending_events[$];  // events still owed by the block
    stim_row_t   directed_rows[$];
    stim_row_t   offered_row   = '0;

    int in_idle_pct   = 0;
    int out_idle_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatch_count = 0;

    sphere_collision_pair_tracker #(
        .MAX_ENTITIES (SLOT_COUNT),
        .COORD_WIDTH  (32)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_slot        (i_slot),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_radius      (i_radius),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_first_slot  (o_first_slot),
        .o_second_slot (o_second_slot),
        .o_last_event  (o_last_event)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // exact contact test: squared distance kept to 66 bits, squared radius sum to 64
    function automatic bit spheres_overlap(input int a, input int b);
        logic [65:0] dist_sq;
        logic [32:0] diff;
        logic [32:0] mag;
        logic [31:0] rsum;
        logic [63:0] rsum_sq;
        if (!slot_present[a] || !slot_present[b]) return 1'b0;
        dist_sq = '0;
        for (int k = 0; k < 3; k++) begin
            diff = {entity_xyz[a][k][31], entity_xyz[a][k]}
                 - {entity_xyz[b][k][31], entity_xyz[b][k]};
            mag  = diff[32] ? -diff : diff;
            dist_sq += {33'd0, mag} * {33'd0, mag};
        end
        rsum    = {1'b0, entity_r[a]} + {1'b0, entity_r[b]};
        rsum_sq = {32'd0, rsum} * {32'd0, rsum};
        return dist_sq <= {2'd0, rsum_sq};
    endfunction

    // applies one accepted beat to the world copy and lists the events it causes
    task automatic advance_world(input logic [1:0] op, input logic [2:0] s,
                                 input logic [31:0] x, input logic [31:0] y,
                                 input logic [31:0] z, input logic [30:0] r);
        bit    hit;
        bit    was;
        t_kind kind;
        walk_events = {};
        if (op == OP_LOAD) begin
            if (s < SLOT_COUNT) begin
                entity_xyz[s][0] = x;
                entity_xyz[s][1] = y;
                entity_xyz[s][2] = z;
                entity_r[s]      = r;
                slot_present[s]  = 1'b1;
            end
        end else if (op == OP_DROP) begin
            if (s < SLOT_COUNT) slot_present[s] = 1'b0;
        end else if (op == OP_FRAME) begin
            // pairs in ascending order, lower slot first
            for (int a = 0; a < SLOT_COUNT; a++) begin
                for (int b = a + 1; b < SLOT_COUNT; b++) begin
                    hit = spheres_overlap(a, b);
                    was = pair_touching[a][b];
                    if (hit && !was) begin
                        kind = EV_ENTER;
                        pair_touching[a][b] = 1'b1;
                    end else if (hit) begin
                        kind = EV_STAY;
                    end else if (was) begin
                        kind = EV_EXIT;
                        pair_touching[a][b] = 1'b0;
                    end else begin
                        continue;
                    end
                    walk_events.push_back('{kind, 3'(a), 3'(b), 1'b0});
                end
            end
            if (walk_events.size() != 0)
                walk_events[walk_events.size() - 1].last_event = 1'b1;
        end
    endtask

    function automatic stim_row_t beat_row(input logic [1:0] op, input logic [2:0] s,
                                           input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z, input logic [30:0] r);
        stim_row_t row;
        row      = '0;
        row.op   = op;
        row.slot = s;
        row.x    = x;
        row.y    = y;
        row.z    = z;
        row.r    = r;
        return row;
    endfunction

    // end-of-frame beat whose outcome is typed in: no event, or exactly one
    function automatic stim_row_t frame_golden(input logic ev, input t_kind k,
                                               input logic [2:0] a, input logic [2:0] b);
        stim_row_t row;
        row              = beat_row(OP_FRAME, 3'd0, Q_ZERO, Q_ZERO, Q_ZERO, R_ZERO);
        row.has_golden   = 1'b1;
        row.golden_event = ev;
        row.golden_kind  = k;
        row.golden_a     = a;
        row.golden_b     = b;
        return row;
    endfunction

    function automatic logic [31:0] cluster_coord();
        return 32'($urandom_range(0, CLUSTER_SPAN)) - (CLUSTER_SPAN >> 1);
    endfunction

    // mostly loads near the origin so pairs keep entering and leaving contact
    function automatic stim_row_t random_row();
        int         roll;
        logic [2:0] s;
        stim_row_t  row;
        roll = $urandom_range(0, 99);
        s    = 3'($urandom_range(0, SLOT_COUNT - 1));
        if (roll < 4)
            row = beat_row(OP_UNUSED, s, $urandom, $urandom, $urandom, 31'($urandom));
        else if (roll < 22)
            row = beat_row(OP_FRAME, s, $urandom, $urandom, $urandom, 31'($urandom));
        else if (roll < 32)
            row = beat_row(OP_DROP, s, $urandom, $urandom, $urandom, 31'($urandom));
        else if (roll < 44)
            row = beat_row(OP_LOAD, s, $urandom, $urandom, $urandom, 31'($urandom));
        else
            row = beat_row(OP_LOAD, s, cluster_coord(), cluster_coord(), cluster_coord(),
                           31'($urandom_range(0, R_CLUSTER)));
        return row;
    endfunction

    // offers one beat after a random idle gap and returns at the edge that takes it
    task automatic offer_beat(input stim_row_t row);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= row.op;
        i_slot      <= row.slot;
        i_pos_x     <= row.x;
        i_pos_y     <= row.y;
        i_pos_z     <= row.z;
        i_radius    <= row.r;
        offered_row <= row;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // sender pause until the block owes nothing
    task automatic wait_for_events();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
    endtask

    task automatic check_event();
        pair_event_t want;
        if (pending_events.size() == 0) begin
            $error("event beat with nothing pending: kind %0d pair %0d,%0d",
                   o_event_kind, o_first_slot, o_second_slot);
            mismatch_count++;
            return;
        end
        want = pending_events.pop_front();
        if (o_event_kind !== want.kind) begin
            $error("event_kind expected %0d actual %0d", want.kind, o_event_kind);
            mismatch_count++;
        end
        if (o_first_slot !== want.first_slot) begin
            $error("first_slot expected %0d actual %0d", want.first_slot, o_first_slot);
            mismatch_count++;
        end
        if (o_second_slot !== want.second_slot) begin
            $error("second_slot expected %0d actual %0d", want.second_slot, o_second_slot);
            mismatch_count++;
        end
        if (o_last_event !== want.last_event) begin
            $error("last_event expected %0d actual %0d", want.last_event, o_last_event);
            mismatch_count++;
        end
    endtask

    // item side: every accepted beat goes through the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            advance_world(i_opcode, i_slot, i_pos_x, i_pos_y, i_pos_z, i_radius);
            if (!offered_row.has_golden) begin
                foreach (walk_events[i]) pending_events.push_back(walk_events[i]);
            end else if (offered_row.golden_event) begin
                pending_events.push_back('{offered_row.golden_kind, offered_row.golden_a,
                                           offered_row.golden_b, 1'b1});
            end
        end
    end

    // event side: check accepted beats, then random stall or a long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_event();
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    // watchdog on cycles in which neither channel moves a beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        stim_row_t plain_frame;
        stim_row_t row;
        int        sent;
        plain_frame = beat_row(OP_FRAME, 3'd0, Q_ZERO, Q_ZERO, Q_ZERO, R_ZERO);
        directed_rows = {
            // frame right after reset: nothing present
            frame_golden(1'b0, EV_ENTER, 3'd0, 3'd0),
            // drop of an absent slot, opcode three with every payload bit set
            beat_row(OP_DROP, 3'd3, Q_ZERO, Q_ZERO, Q_ZERO, R_ZERO),
            beat_row(OP_UNUSED, 3'd7, '1, '1, '1, '1),
            // unit spheres two apart: distance exactly equals the radius sum
            beat_row(OP_LOAD, 3'd0, Q_ZERO, Q_ZERO, Q_ZERO, R_ONE),
            beat_row(OP_LOAD, 3'd1, Q_TWO, Q_ZERO, Q_ZERO, R_ONE),
            frame_golden(1'b1, EV_ENTER, 3'd0, 3'd1),
            frame_golden(1'b1, EV_STAY, 3'd0, 3'd1),
            // one lsb further apart: contact lost
            beat_row(OP_LOAD, 3'd1, Q_TWO_PLUS, Q_ZERO, Q_ZERO, R_ONE),
            frame_golden(1'b1, EV_EXIT, 3'd0, 3'd1),
            frame_golden(1'b0, EV_ENTER, 3'd0, 3'd0),
            // opposite corners, largest radius: squared distance beyond 64 bits
            beat_row(OP_LOAD, 3'd7, COORD_MAX, COORD_MIN, COORD_MAX, R_MAX),
            beat_row(OP_LOAD, 3'd6, COORD_MIN, COORD_MAX, COORD_MIN, R_MAX),
            plain_frame,
            // zero-radius points sitting on slot 6
            beat_row(OP_LOAD, 3'd5, COORD_MIN, COORD_MAX, COORD_MIN, R_ZERO),
            beat_row(OP_LOAD, 3'd4, COORD_MIN, COORD_MAX, COORD_MIN, R_ZERO),
            plain_frame,
            // absent slot: its active pairs exit
            beat_row(OP_DROP, 3'd5, Q_ZERO, Q_ZERO, Q_ZERO, R_ZERO),
            plain_frame,
            beat_row(OP_DROP, 3'd5, Q_ZERO, Q_ZERO, Q_ZERO, R_ZERO),
            beat_row(OP_LOAD, 3'd1, Q_TWO, Q_ZERO, Q_ZERO, R_ONE),
            plain_frame,
            beat_row(OP_DROP, 3'd0, Q_ZERO, Q_ZERO, Q_ZERO, R_ZERO),
            plain_frame,
            beat_row(OP_LOAD, 3'd2, COORD_MAX, COORD_MAX, COORD_MAX, R_ZERO),
            beat_row(OP_LOAD, 3'd3, COORD_MAX, COORD_MAX, COORD_MAX, R_ZERO),
            plain_frame
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_idle_pct = 8;
        out_idle_pct <= 81;
        @(posedge i_clk);

        foreach (directed_rows[i]) offer_beat(directed_rows[i]);
        wait_for_events();

        // back-pressure: all slots overlap, so every frame owes 28 events;
        // the consumer holds off while frames keep coming
        for (int s = 0; s < SLOT_COUNT; s++)
            offer_beat(beat_row(OP_LOAD, 3'(s), Q_ZERO, Q_ZERO, Q_ZERO, R_ONE));
        hold_requests <= hold_requests + 1;
        repeat (4) offer_beat(plain_frame);
        wait_for_events();

        // idle phases: sender light / consumer heavy, swapped, then none
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct = 8;
                    out_idle_pct <= 81;
                end
                1: begin
                    in_idle_pct = 81;
                    out_idle_pct <= 8;
                end
                default: begin
                    in_idle_pct = 0;
                    out_idle_pct <= 0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_BEATS) begin
                row = random_row();
                offer_beat(row);
                if (row.op != OP_UNUSED) sent++;
            end
            wait_for_events();
        end

        // a walk with no events may still be running
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_events.size() != 0)
            $error("%0d events never arrived", pending_events.size());
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
sv/sphc_pkg.sv
sv/sphc_ram.sv
sv/sphc_dp.sv
sv/sphc_ctrl.sv
sv/sphere_collision_pair_tracker.sv
verif/sphere_collision_pair_tracker_tb.sv
